// ===== rtl/core/mbb_pkg.sv =====
// Shared types, widths, register indexes and reset values of the mask bounding box block.
package mbb_pkg;

  localparam int unsigned DIM_W      = 11;
  localparam int unsigned STRIDE_W   = 8;
  localparam int unsigned BYTE_IDX_W = 7;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned OUT_DATA_W = 48;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE  = 4'd3;

  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 11'd400;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 11'd240;
  localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE   = 8'd52;
  localparam logic                RST_MASK_ENABLE  = 1'b1;

  localparam logic [STRIDE_W-1:0] STRIDE_MIN = 8'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_MAX = 8'd128;

  // Set-pixel span found in one mask byte.
  typedef struct packed {
    logic             hit;
    logic [DIM_W-1:0] col_lo;
    logic [DIM_W-1:0] col_hi;
  } scan_t;

endpackage

// ===== rtl/core/mbb_byte_scan.sv =====
// Masks one byte against the image width and priority-encodes its leftmost and rightmost set pixel.
module mbb_byte_scan (
  input  logic [7:0]                mask_byte,
  input  logic [mbb_pkg::DIM_W-1:0] base_col,
  input  logic [mbb_pkg::DIM_W-1:0] width,
  output mbb_pkg::scan_t            scan
);

  logic [7:0] valid_px;
  logic [7:0] set_px;
  logic [2:0] first_px;
  logic [2:0] last_px;

  // Pixel k of the byte sits in bit 7-k; it counts only left of the width.
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      valid_px[k] = (base_col + mbb_pkg::DIM_W'(k)) < width;
      set_px[k]   = mask_byte[7-k] & valid_px[k];
    end
  end

  always_comb begin
    first_px = 3'd0;
    last_px  = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (set_px[k]) begin
        first_px = 3'(k);
      end
    end
    for (int k = 0; k < 8; k++) begin
      if (set_px[k]) begin
        last_px = 3'(k);
      end
    end
  end

  assign scan.hit    = |set_px;
  assign scan.col_lo = base_col + mbb_pkg::DIM_W'(first_px);
  assign scan.col_hi = base_col + mbb_pkg::DIM_W'(last_px) + 11'd1;

endmodule

// ===== rtl/core/mask_bounding_box.sv =====
// Top level of the mask bounding box block: input register, box tracking and result register.
//
// The block takes a 1-bit mask image one byte per item in raster order, row_stride_bytes
// bytes per row, bit 7 of each byte being the leftmost pixel, and tracks the smallest and
// one-past-largest column and row holding a set pixel. Pixels at or past image_width are
// ignored, as are rows at or past image_height. When the last byte of the last row has been
// processed one result item (box_x, box_y, box_width, box_height) is emitted and a new frame
// starts; an empty mask gives all zeros, and with mask_enable at 0 the result is the whole
// image (0, 0, width, height). Widths above MAX_WIDTH and heights above MAX_HEIGHT are
// clamped; a stride of 0 acts as 1 and one above 128 as 128. Each item is caught in an
// input register, and from there the byte scan (an 8-way width mask and priority encode)
// and the min/max update run and write the box registers and, at frame end, the result
// register. Items are accepted back to back; the input side stalls only when a frame-ending
// byte finds the previous result still waiting on the output. Configuration writes are
// always accepted and should be made while the block is idle.
module mask_bounding_box #(
  parameter int unsigned MAX_WIDTH  = mbb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = mbb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbb_pkg::CFG_DATA_W-1:0] cfg_data,
  // Mask byte input.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] mask_byte
  // Box result output.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [10:0] box_x, [21:11] box_y, [32:22] box_width, [43:33] box_height, [47:44] zero
  output logic [mbb_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int unsigned DW = mbb_pkg::DIM_W;
  localparam int unsigned SW = mbb_pkg::STRIDE_W;
  localparam int unsigned BW = mbb_pkg::BYTE_IDX_W;

  // Limits held two bits wider than the 11-bit registers so the compare is exact.
  localparam logic [12:0] MAX_W_L = 13'(MAX_WIDTH);
  localparam logic [12:0] MAX_H_L = 13'(MAX_HEIGHT);

  // Configuration registers.
  logic [DW-1:0] image_width_r;
  logic [DW-1:0] image_height_r;
  logic [SW-1:0] row_stride_r;
  logic          mask_enable_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= mbb_pkg::RST_IMAGE_WIDTH;
      image_height_r <= mbb_pkg::RST_IMAGE_HEIGHT;
      row_stride_r   <= mbb_pkg::RST_ROW_STRIDE;
      mask_enable_r  <= mbb_pkg::RST_MASK_ENABLE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbb_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[DW-1:0];
        mbb_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_data[DW-1:0];
        mbb_pkg::REG_ROW_STRIDE:   row_stride_r   <= cfg_data[SW-1:0];
        mbb_pkg::REG_MASK_ENABLE:  mask_enable_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Effective geometry after clamping.
  logic [DW-1:0] eff_w;
  logic [DW-1:0] eff_h;
  logic [SW-1:0] eff_stride;

  always_comb begin
    eff_w = (13'(image_width_r) > MAX_W_L) ? MAX_W_L[DW-1:0] : image_width_r;
    eff_h = (13'(image_height_r) > MAX_H_L) ? MAX_H_L[DW-1:0] : image_height_r;
    if (row_stride_r < mbb_pkg::STRIDE_MIN) begin
      eff_stride = mbb_pkg::STRIDE_MIN;
    end else if (row_stride_r > mbb_pkg::STRIDE_MAX) begin
      eff_stride = mbb_pkg::STRIDE_MAX;
    end else begin
      eff_stride = row_stride_r;
    end
  end

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_go;
  logic       out_free;

  // Frame position and box gathered so far.
  logic          found_r;
  logic [DW-1:0] row_count_r;
  logic [BW-1:0] byte_in_row_r;
  logic [DW-1:0] least_col_r;
  logic [DW-1:0] past_col_r;
  logic [DW-1:0] least_row_r;
  logic [DW-1:0] past_row_r;

  logic          found_nxt;
  logic [DW-1:0] least_col_nxt;
  logic [DW-1:0] past_col_nxt;
  logic [DW-1:0] least_row_nxt;
  logic [DW-1:0] past_row_nxt;

  logic [DW-1:0] base_col;
  logic [DW:0]   row_inc;
  logic          row_end;
  logic          frame_end;
  logic          row_hit;
  mbb_pkg::scan_t scan;

  function automatic logic [DW-4:0] base_col_hi(input logic [BW-1:0] idx);
    base_col_hi = (DW-3)'(idx);
  endfunction

  assign base_col = {base_col_hi(byte_in_row_r), 3'b000};

  mbb_byte_scan u_scan (
    .mask_byte (s1_byte_r),
    .base_col  (base_col),
    .width     (eff_w),
    .scan      (scan)
  );

  assign row_inc   = {1'b0, row_count_r} + 12'd1;
  assign row_end   = ({1'b0, byte_in_row_r} + 8'd1) >= eff_stride;
  assign frame_end = row_end && (row_inc >= {1'b0, eff_h});
  assign row_hit   = scan.hit && (row_count_r < eff_h);

  // A byte that ends a frame needs the result register free; any other byte always moves.
  assign out_free  = !out_tvalid || out_tready;
  assign s1_go     = s1_valid_r && (!frame_end || out_free);
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  // Merge this byte's span into the box; the first hit of a frame seeds it.
  always_comb begin
    found_nxt     = found_r;
    least_col_nxt = least_col_r;
    past_col_nxt  = past_col_r;
    least_row_nxt = least_row_r;
    past_row_nxt  = past_row_r;
    if (row_hit) begin
      found_nxt = 1'b1;
      if (!found_r) begin
        least_col_nxt = scan.col_lo;
        past_col_nxt  = scan.col_hi;
        least_row_nxt = row_count_r;
        past_row_nxt  = row_inc[DW-1:0];
      end else begin
        if (scan.col_lo < least_col_r) begin
          least_col_nxt = scan.col_lo;
        end
        if (scan.col_hi > past_col_r) begin
          past_col_nxt = scan.col_hi;
        end
        if (row_count_r < least_row_r) begin
          least_row_nxt = row_count_r;
        end
        if (row_inc[DW-1:0] > past_row_r) begin
          past_row_nxt = row_inc[DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r       <= 1'b0;
      row_count_r   <= '0;
      byte_in_row_r <= '0;
      least_col_r   <= '0;
      past_col_r    <= '0;
      least_row_r   <= '0;
      past_row_r    <= '0;
    end else if (s1_go) begin
      if (frame_end) begin
        found_r       <= 1'b0;
        row_count_r   <= '0;
        byte_in_row_r <= '0;
        least_col_r   <= '0;
        past_col_r    <= '0;
        least_row_r   <= '0;
        past_row_r    <= '0;
      end else begin
        found_r       <= found_nxt;
        least_col_r   <= least_col_nxt;
        past_col_r    <= past_col_nxt;
        least_row_r   <= least_row_nxt;
        past_row_r    <= past_row_nxt;
        if (row_end) begin
          byte_in_row_r <= '0;
          row_count_r   <= row_inc[DW-1:0];
        end else begin
          byte_in_row_r <= byte_in_row_r + 7'd1;
        end
      end
    end
  end

  // Result of the frame, taken from the box including the byte that ends it.
  logic [DW-1:0] res_x;
  logic [DW-1:0] res_y;
  logic [DW-1:0] res_w;
  logic [DW-1:0] res_h;

  always_comb begin
    res_x = '0;
    res_y = '0;
    res_w = '0;
    res_h = '0;
    if (!mask_enable_r) begin
      res_w = eff_w;
      res_h = eff_h;
    end else if (found_nxt) begin
      res_x = least_col_nxt;
      res_y = least_row_nxt;
      res_w = past_col_nxt - least_col_nxt;
      res_h = past_row_nxt - least_row_nxt;
    end
  end

  // Result register.
  logic                           out_valid_r;
  logic [mbb_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && frame_end) begin
      out_data_r <= {4'b0000, res_h, res_w, res_y, res_x};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== test/box_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the bounding boxes of the mask bounding box block.
`timescale 1ns / 1ps

package box_scoreboard_pkg;

  typedef struct {
    logic [mbb_pkg::DIM_W-1:0] x;
    logic [mbb_pkg::DIM_W-1:0] y;
    logic [mbb_pkg::DIM_W-1:0] w;
    logic [mbb_pkg::DIM_W-1:0] h;
  } box_t;

  class box_scoreboard;
    // Register copies, as written over the configuration channel.
    logic [mbb_pkg::DIM_W-1:0]    width_reg;
    logic [mbb_pkg::DIM_W-1:0]    height_reg;
    logic [mbb_pkg::STRIDE_W-1:0] stride_reg;
    logic                         enable_reg;

    // Frame position and the box gathered so far.
    int unsigned rows_done;
    int unsigned byte_col;
    bit          any_set;
    int unsigned col_lo;
    int unsigned col_end;
    int unsigned row_lo;
    int unsigned row_end;

    box_t        boxes_due[$];
    int unsigned errors;

    function new();
      width_reg  = mbb_pkg::RST_IMAGE_WIDTH;
      height_reg = mbb_pkg::RST_IMAGE_HEIGHT;
      stride_reg = mbb_pkg::RST_ROW_STRIDE;
      enable_reg = mbb_pkg::RST_MASK_ENABLE;
      errors     = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      rows_done = 0;
      byte_col  = 0;
      any_set   = 0;
      col_lo    = 0;
      col_end   = 0;
      row_lo    = 0;
      row_end   = 0;
    endfunction

    function void apply_reg(logic [mbb_pkg::CFG_IDX_W-1:0] idx,
                            logic [mbb_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        mbb_pkg::REG_IMAGE_WIDTH:  width_reg  = data[mbb_pkg::DIM_W-1:0];
        mbb_pkg::REG_IMAGE_HEIGHT: height_reg = data[mbb_pkg::DIM_W-1:0];
        mbb_pkg::REG_ROW_STRIDE:   stride_reg = data[mbb_pkg::STRIDE_W-1:0];
        mbb_pkg::REG_MASK_ENABLE:  enable_reg = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      return (width_reg > mbb_pkg::DEF_MAX_WIDTH) ? mbb_pkg::DEF_MAX_WIDTH : width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg > mbb_pkg::DEF_MAX_HEIGHT) ? mbb_pkg::DEF_MAX_HEIGHT : height_reg;
    endfunction

    function int unsigned eff_stride();
      if (stride_reg < mbb_pkg::STRIDE_MIN) return mbb_pkg::STRIDE_MIN;
      if (stride_reg > mbb_pkg::STRIDE_MAX) return mbb_pkg::STRIDE_MAX;
      return stride_reg;
    endfunction

    // A zero height still ends the frame after one row.
    function int unsigned frame_bytes();
      return eff_stride() * ((eff_height() == 0) ? 1 : eff_height());
    endfunction

    function int unsigned pending();
      return boxes_due.size();
    endfunction

    // Advances the prediction by one accepted mask byte.
    function void note_byte(logic [7:0] pixels);
      int unsigned w;
      int unsigned h;
      int unsigned base;
      int unsigned n;
      int unsigned first;
      int unsigned last;
      logic [7:0]  live;
      logic [7:0]  m;
      box_t        b;
      w    = eff_width();
      h    = eff_height();
      base = byte_col * 8;
      n    = (w > base) ? (w - base) : 0;
      live = (n >= 8) ? 8'hFF : 8'((32'hFF << (8 - n)) & 32'hFF);
      m    = pixels & live;

      if (m != 8'h00 && rows_done < h) begin
        first = 0;
        while (!m[7 - first]) first++;
        last = 7;
        while (!m[7 - last]) last--;
        if (!any_set) begin
          any_set = 1;
          col_lo  = base + first;
          col_end = base + last + 1;
          row_lo  = rows_done;
          row_end = rows_done + 1;
        end else begin
          if (base + first < col_lo) col_lo = base + first;
          if (base + last + 1 > col_end) col_end = base + last + 1;
          if (rows_done < row_lo) row_lo = rows_done;
          if (rows_done + 1 > row_end) row_end = rows_done + 1;
        end
      end

      if (byte_col + 1 >= eff_stride()) begin
        byte_col = 0;
        rows_done++;
        if (rows_done >= h) begin
          b.x = '0;
          b.y = '0;
          b.w = '0;
          b.h = '0;
          if (!enable_reg) begin
            b.w = mbb_pkg::DIM_W'(w);
            b.h = mbb_pkg::DIM_W'(h);
          end else if (any_set) begin
            b.x = mbb_pkg::DIM_W'(col_lo);
            b.y = mbb_pkg::DIM_W'(row_lo);
            b.w = mbb_pkg::DIM_W'(col_end - col_lo);
            b.h = mbb_pkg::DIM_W'(row_end - row_lo);
          end
          boxes_due.push_back(b);
          clear_frame();
        end
      end else begin
        byte_col++;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compares one accepted result with the oldest box still due.
    task check_box(logic [mbb_pkg::OUT_DATA_W-1:0] d);
      box_t                                            due;
      logic [mbb_pkg::DIM_W-1:0]                       gx;
      logic [mbb_pkg::DIM_W-1:0]                       gy;
      logic [mbb_pkg::DIM_W-1:0]                       gw;
      logic [mbb_pkg::DIM_W-1:0]                       gh;
      logic [mbb_pkg::OUT_DATA_W-4*mbb_pkg::DIM_W-1:0] pad;
      gx  = d[mbb_pkg::DIM_W-1:0];
      gy  = d[2*mbb_pkg::DIM_W-1:mbb_pkg::DIM_W];
      gw  = d[3*mbb_pkg::DIM_W-1:2*mbb_pkg::DIM_W];
      gh  = d[4*mbb_pkg::DIM_W-1:3*mbb_pkg::DIM_W];
      pad = d[mbb_pkg::OUT_DATA_W-1:4*mbb_pkg::DIM_W];
      if (boxes_due.size() == 0) begin
        report($sformatf("box result 0x%h arrived with no frame pending", d));
      end else begin
        due = boxes_due.pop_front();
        if (gx !== due.x) report($sformatf("box_x got %0d expected %0d", gx, due.x));
        if (gy !== due.y) report($sformatf("box_y got %0d expected %0d", gy, due.y));
        if (gw !== due.w) report($sformatf("box_width got %0d expected %0d", gw, due.w));
        if (gh !== due.h) report($sformatf("box_height got %0d expected %0d", gh, due.h));
        if (pad !== '0) report($sformatf("padding bits got 0x%h expected zero", pad));
      end
    endtask
  endclass

endpackage

// ===== test/testbench.sv =====
// Top-level testbench of the mask bounding box block: stimulus, flow control and checking.
`timescale 1ns / 1ps

module testbench;

  // How the bytes of one frame are filled.
  typedef enum {FILL_EMPTY, FILL_FULL, FILL_DENSE, FILL_SPARSE} fill_t;

  localparam int unsigned RANDOM_ITEMS = 650;
  // Length of the deliberate output hold-off, in clock cycles.
  localparam int unsigned LONG_STALL   = 300;
  // Cycles left for bytes still inside the block once no box is due.
  localparam int unsigned SETTLE       = 8;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [mbb_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [mbb_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [7:0]                     in_tdata   = '0;   // [7:0] mask_byte
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // [10:0] box_x, [21:11] box_y, [32:22] box_width, [43:33] box_height, [47:44] zero
  logic [mbb_pkg::OUT_DATA_W-1:0] out_tdata;

  box_scoreboard_pkg::box_scoreboard sb;

  // Idle rates in percent; they change as the run moves through its stages.
  int unsigned in_idle_pct  = 34;
  int unsigned out_idle_pct = 54;

  // The stimulus toggles stall_req to ask for one long hold-off on the output side.
  bit          stall_req  = 1'b0;
  bit          stall_seen = 1'b0;
  int unsigned stall_left = 0;

  int unsigned random_items = 0;

  mask_bounding_box DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Result side: random back-pressure, plus the long hold-off when one is asked for.
  // The hold-off is counted here so that the sender keeps offering bytes meanwhile.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Every accepted box goes to the scoreboard. Values read here are those from before
  // the edge, since both the block and the drivers update with nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_box(out_tdata);
  end

  // One register write. cfg_valid stays high so that writes can go back to back;
  // the caller lowers it after the last one.
  task cfg_write(input logic [mbb_pkg::CFG_IDX_W-1:0] idx,
                 input logic [mbb_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
  endtask

  // Writes all four registers; only called while the block is idle.
  task set_frame(input logic [mbb_pkg::CFG_DATA_W-1:0] width,
                 input logic [mbb_pkg::CFG_DATA_W-1:0] height,
                 input logic [mbb_pkg::CFG_DATA_W-1:0] stride,
                 input logic [mbb_pkg::CFG_DATA_W-1:0] enable);
    cfg_write(mbb_pkg::REG_IMAGE_WIDTH, width);
    cfg_write(mbb_pkg::REG_IMAGE_HEIGHT, height);
    cfg_write(mbb_pkg::REG_ROW_STRIDE, stride);
    cfg_write(mbb_pkg::REG_MASK_ENABLE, enable);
    cfg_valid <= 1'b0;
  endtask

  // Offers one mask byte, with a random gap before it, and waits for it to be taken.
  task send_byte(input logic [7:0] pixels);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pixels;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(pixels);
  endtask

  // The sender stops until every box due has come out, then leaves a few cycles for
  // bytes that end no frame but may still be inside the block.
  task wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function logic [7:0] fill_byte(fill_t fill);
    int unsigned r;
    r = $urandom_range(99);
    case (fill)
      FILL_EMPTY: return 8'h00;
      FILL_FULL:  return 8'hFF;
      FILL_DENSE: return 8'($urandom);
      default:    begin
        // Mostly blank bytes so that boxes stay small and land anywhere in the frame.
        if (r < 6) return 8'(1 << $urandom_range(7));
        if (r < 12) return 8'($urandom);
        return 8'h00;
      end
    endcase
  endfunction

  // Sends one whole frame under the current settings.
  task send_frame(input fill_t fill, input bit counted);
    int unsigned n;
    n = sb.frame_bytes();
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(fill_byte(fill));
      if (counted) random_items++;
    end
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned s;
    int unsigned en;
    int unsigned r;
    int unsigned frames;
    fill_t       fill;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames. Two bits in different rows and bytes: box (7, 0, 2, 2).
    set_frame(16, 2, 2, 1);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h01);
    send_byte(8'h00);
    // One full byte is a full box.
    wait_idle();
    set_frame(8, 1, 1, 1);
    send_byte(8'hFF);
    // An empty mask gives an all-zero box.
    wait_idle();
    set_frame(8, 2, 1, 1);
    send_byte(8'h00);
    send_byte(8'h00);
    // With the mask off the box is the whole image, whatever the bytes.
    wait_idle();
    set_frame(12, 3, 2, 0);
    repeat (6) send_byte(8'($urandom));
    // A zero height ends the frame after one row and ignores its bits.
    wait_idle();
    set_frame(16, 0, 2, 1);
    send_byte(8'hFF);
    send_byte(8'hFF);
    wait_idle();
    set_frame(16, 0, 2, 0);
    send_byte(8'h55);
    send_byte(8'hAA);
    // A zero width counts no pixel, masked or not.
    wait_idle();
    set_frame(0, 1, 1, 1);
    send_byte(8'hFF);
    wait_idle();
    set_frame(0, 2, 1, 0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // A width past the stride: the columns beyond the last byte are never set.
    wait_idle();
    set_frame(20, 1, 1, 1);
    send_byte(8'hFF);
    // A width ending inside a byte drops the low bits of that byte.
    wait_idle();
    set_frame(5, 1, 1, 1);
    send_byte(8'hFF);

    // Widest row: width clamped to 1024, stride clamped to 128, one bit in the last column.
    wait_idle();
    set_frame(2047, 1, 255, 1);
    for (int unsigned i = 0; i < 128; i++) send_byte((i == 127) ? 8'h01 : 8'h00);
    // Unmasked oversized image: the box is the clamped width.
    wait_idle();
    set_frame(2047, 1, 200, 0);
    send_frame(FILL_DENSE, 1'b0);

    // Back-pressure: every byte ends a frame while the output is held off, so the block
    // fills up and must stall its input. Then the sender waits for every box.
    wait_idle();
    set_frame(8, 1, 1, 1);
    stall_req <= ~stall_req;
    repeat (16) send_byte(fill_byte(FILL_SPARSE));
    wait_idle();

    // Random frames, a fresh setting for each group of frames.
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        in_idle_pct  = 34;
        out_idle_pct = 54;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 54;
        out_idle_pct = 34;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end

      wait_idle();
      r      = $urandom_range(99);
      frames = $urandom_range(1, 4);
      if (r < 4) begin
        // Wide rows near the clamps; kept short.
        w      = ($urandom_range(1) != 0) ? $urandom_range(1000, 2047) :
                 mbb_pkg::DEF_MAX_WIDTH;
        h      = $urandom_range(0, 2);
        s      = ($urandom_range(1) != 0) ? $urandom_range(120, 255) : mbb_pkg::STRIDE_MAX;
        frames = 1;
      end else if (r < 12) begin
        // Degenerate sizes.
        w = ($urandom_range(1) != 0) ? 0 : $urandom_range(1, 40);
        h = ($urandom_range(1) != 0) ? 0 : $urandom_range(1, 6);
        s = $urandom_range(0, 5);
      end else begin
        w = $urandom_range(1, 48);
        h = $urandom_range(1, 6);
        s = $urandom_range(0, 7);
      end
      en = ($urandom_range(9) != 0) ? 1 : 0;
      // Bits above the stride and enable registers' widths are written too; the block must drop them.
      set_frame(mbb_pkg::CFG_DATA_W'(w), mbb_pkg::CFG_DATA_W'(h),
                mbb_pkg::CFG_DATA_W'(($urandom_range(7) << mbb_pkg::STRIDE_W) | s),
                mbb_pkg::CFG_DATA_W'(($urandom & 32'h7FE) | en));

      for (int unsigned f = 0; f < frames; f++) begin
        r = $urandom_range(9);
        fill = (r == 0) ? FILL_EMPTY : (r == 1) ? FILL_FULL :
               (r < 4) ? FILL_DENSE : FILL_SPARSE;
        send_frame(fill, 1'b1);
      end
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake: far longer than the slowest correct run.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
